// ===== rtl/fcc_pkg.sv =====
// Shared types, character constants and helper functions of the file-name cipher.
// No dependencies; every other file takes its names by scoped reference.
package fcc_pkg;

    // Key store
    localparam int unsigned KEY_CHARS  = 5;
    localparam int unsigned KEY_WIDTH  = 8 * KEY_CHARS;
    localparam logic [KEY_WIDTH-1:0] KEY_TEXT_RESET = 40'h504F534953;
    localparam logic [2:0] KEY_LEN_MAX   = 3'd5;
    localparam logic [2:0] KEY_LEN_MIN   = 3'd1;
    localparam logic [2:0] KEY_LEN_RESET = 3'd5;

    // Configuration register indexes
    localparam logic REG_KEY_TEXT   = 1'b0;
    localparam logic REG_KEY_LENGTH = 1'b1;

    // ASCII codes
    localparam logic [6:0] CHR_DOT     = 7'h2E;
    localparam logic [6:0] CHR_UPPER_A = 7'h41;
    localparam logic [6:0] CHR_UPPER_Z = 7'h5A;
    localparam logic [6:0] CHR_LOWER_A = 7'h61;
    localparam logic [6:0] CHR_LOWER_Z = 7'h7A;

    // Atbash reflects about the middle of the alphabet: 'A'+'Z' and 'a'+'z'
    localparam logic [7:0] MIRROR_UPPER_SUM = 8'd155;
    localparam logic [7:0] MIRROR_LOWER_SUM = 8'd219;

    localparam logic [5:0] ROT_SHIFT    = 6'd13;
    localparam logic [5:0] ALPHA_LEN    = 6'd26;
    localparam logic [9:0] DEC_BIAS     = 10'd260;

    // floor(x / 26) for x < 512 as (x * 631) >> 14
    localparam logic [9:0] MOD26_RECIP = 10'd631;
    localparam int unsigned MOD26_SHIFT = 14;

    // Commands
    typedef enum logic [2:0] {
        CMD_PASS       = 3'd0,
        CMD_ATBASH     = 3'd1,
        CMD_ATBASH_ROT = 3'd2,
        CMD_ATBASH_VIG = 3'd3,
        CMD_VIG_DEC    = 3'd4
    } cmd_t;

    // Input request
    typedef struct packed {
        logic [6:0] char_in;
        logic [2:0] command;
        logic       name_start;
        logic       name_end;
    } in_req_t;

    // Result
    typedef struct packed {
        logic [6:0] char_out;
        logic       last_out;
    } out_res_t;

    // Per-name running state
    typedef struct packed {
        logic       past_dot;
        logic [2:0] key_position;
    } name_state_t;

    // Remainder modulo 26 of a 9-bit value by reciprocal multiplication
    function automatic logic [4:0] mod26(input logic [8:0] x);
        logic [18:0] prod;
        logic [4:0]  quot;
        logic [9:0]  back;
        logic [8:0]  rem;
        prod = 19'(x) * 19'(MOD26_RECIP);
        quot = prod[MOD26_SHIFT +: 5];
        back = 10'(quot) * 10'(ALPHA_LEN);
        rem  = x - back[8:0];
        return rem[4:0];
    endfunction

endpackage

// ===== rtl/fcc_xform.sv =====
// Character transform and key/dot state update for one request.
// Purely combinational; uses types, constants and mod26 from fcc_pkg.
module fcc_xform (
    input  fcc_pkg::in_req_t                  req,
    input  fcc_pkg::name_state_t              cur_state,
    input  logic [fcc_pkg::KEY_WIDTH-1:0]     key_text,
    input  logic [2:0]                        key_length,
    output fcc_pkg::out_res_t                 res,
    output fcc_pkg::name_state_t              next_state
);

    logic [6:0] c;
    logic       dot_in;
    logic       dot_now;
    logic [2:0] pos_in;
    logic [2:0] len;
    logic [2:0] pos;
    logic [2:0] pos_inc;
    logic [7:0] k;
    logic       is_upper;
    logic       is_lower;
    logic [6:0] mir;
    logic [6:0] base;
    logic [5:0] off13;
    logic [6:0] rot;
    logic [8:0] enc_sum;
    logic [9:0] dec_sum;
    logic [6:0] enc;
    logic [6:0] dec;
    logic [6:0] xf;

    always_comb begin
        c = req.char_in;

        // Restart dot flag and key position at a new name
        dot_in  = req.name_start ? 1'b0 : cur_state.past_dot;
        pos_in  = req.name_start ? 3'd0 : cur_state.key_position;
        dot_now = dot_in | (c == fcc_pkg::CHR_DOT);

        // Clamp key length into 1..5
        if (key_length < fcc_pkg::KEY_LEN_MIN) begin
            len = fcc_pkg::KEY_LEN_MIN;
        end else if (key_length > fcc_pkg::KEY_LEN_MAX) begin
            len = fcc_pkg::KEY_LEN_MAX;
        end else begin
            len = key_length;
        end
        pos     = (pos_in < len) ? pos_in : 3'd0;
        pos_inc = pos + 3'd1;

        // Select key byte
        case (pos)
            3'd1:    k = key_text[15:8];
            3'd2:    k = key_text[23:16];
            3'd3:    k = key_text[31:24];
            3'd4:    k = key_text[39:32];
            default: k = key_text[7:0];
        endcase

        // Atbash
        is_upper = (c >= fcc_pkg::CHR_UPPER_A) && (c <= fcc_pkg::CHR_UPPER_Z);
        is_lower = (c >= fcc_pkg::CHR_LOWER_A) && (c <= fcc_pkg::CHR_LOWER_Z);
        if (is_upper) begin
            mir = 7'(fcc_pkg::MIRROR_UPPER_SUM - 8'(c));
        end else if (is_lower) begin
            mir = 7'(fcc_pkg::MIRROR_LOWER_SUM - 8'(c));
        end else begin
            mir = c;
        end

        // ROT13 of the mirrored letter (case is kept by Atbash)
        base  = is_lower ? fcc_pkg::CHR_LOWER_A : fcc_pkg::CHR_UPPER_A;
        off13 = 6'(mir - base) + fcc_pkg::ROT_SHIFT;
        if (off13 >= fcc_pkg::ALPHA_LEN) begin
            off13 = off13 - fcc_pkg::ALPHA_LEN;
        end
        rot = (is_upper || is_lower) ? (base + 7'(off13)) : mir;

        // Vigenere variant, encrypt after Atbash and plain decrypt
        enc_sum = 9'(mir) + 9'(k);
        dec_sum = 10'(c) + fcc_pkg::DEC_BIAS - 10'(k);
        enc     = fcc_pkg::CHR_UPPER_A + 7'(fcc_pkg::mod26(enc_sum));
        dec     = fcc_pkg::CHR_UPPER_A + 7'(fcc_pkg::mod26(dec_sum[8:0]));

        case (req.command)
            fcc_pkg::CMD_ATBASH:     xf = mir;
            fcc_pkg::CMD_ATBASH_ROT: xf = rot;
            fcc_pkg::CMD_ATBASH_VIG: xf = enc;
            fcc_pkg::CMD_VIG_DEC:    xf = dec;
            default:                 xf = c;
        endcase

        // Past the dot: pass and hold the key; otherwise transform and advance
        res.last_out = req.name_end;
        if (dot_now) begin
            res.char_out            = c;
            next_state.past_dot     = 1'b1;
            next_state.key_position = pos_in;
        end else begin
            res.char_out            = xf;
            next_state.past_dot     = 1'b0;
            next_state.key_position = (pos_inc >= len) ? 3'd0 : pos_inc;
        end
    end

endmodule

// ===== rtl/filename_classical_cipher.sv =====
// Top level of the file-name cipher: request register, transform, result register.
// Depends on fcc_pkg and fcc_xform.
//
// Usage:
//   A request on s_req (character, command, name_start, name_end) is taken when
//   s_valid and s_ready are both high. Each request gives exactly one result
//   on m_res (character, last flag), taken when m_valid and m_ready are high.
//   Results leave in request order.
//   A taken request waits in the request register and moves through the transform
//   into the result register once it is free, and can be taken from there.
//   Throughput: one request per cycle while m_ready is high, set by the single
//   register stage in front of the transform and the result register after it.
//   The key position and dot flag are updated as a request moves into the
//   result register, so back-to-back characters of a name see each other.
//   When the receiver stalls, the result register holds and the request
//   register fills; s_ready falls only while both are full and m_ready is low.
//   Reset (aresetn low at a clock edge) empties both stages, clears the dot flag
//   and key position and loads the key "SISOP" with length 5.
//   The key registers are written through cfg_we/cfg_index/cfg_wdata; the user
//   must write them only while the block holds no request (not enforced here).
module filename_classical_cipher (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  fcc_pkg::in_req_t               s_req,
    output logic                           m_valid,
    input  logic                           m_ready,
    output fcc_pkg::out_res_t              m_res,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [fcc_pkg::KEY_WIDTH-1:0]  cfg_wdata
);

    logic                          in_valid_reg;
    fcc_pkg::in_req_t              in_req_reg;
    logic                          out_valid_reg;
    fcc_pkg::out_res_t             out_res_reg;
    fcc_pkg::name_state_t          state_reg;
    fcc_pkg::name_state_t          state_next;
    fcc_pkg::out_res_t             res_next;
    logic [fcc_pkg::KEY_WIDTH-1:0] key_text_reg;
    logic [2:0]                    key_length_reg;
    logic                          advance;

    // Move the held request into the result register when that slot frees up
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_res   = out_res_reg;

    fcc_xform u_xform (
        .req        (in_req_reg),
        .cur_state  (state_reg),
        .key_text   (key_text_reg),
        .key_length (key_length_reg),
        .res        (res_next),
        .next_state (state_next)
    );

    // Pipeline control and name state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
                if (in_valid_reg) begin
                    state_reg <= state_next;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_req_reg <= s_req;
        end
        if (advance && in_valid_reg) begin
            out_res_reg <= res_next;
        end
    end

    // Key configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_text_reg   <= fcc_pkg::KEY_TEXT_RESET;
            key_length_reg <= fcc_pkg::KEY_LEN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                fcc_pkg::REG_KEY_TEXT:   key_text_reg   <= cfg_wdata;
                fcc_pkg::REG_KEY_LENGTH: key_length_reg <= cfg_wdata[2:0];
                default:                 key_text_reg   <= key_text_reg;
            endcase
        end
    end

endmodule

// ===== rtl/fcc_checker.sv =====
// Port-level checks of the file-name cipher, bound to the top level.
// Depends on fcc_pkg and filename_classical_cipher.
module fcc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input fcc_pkg::in_req_t  s_req,
    input logic              m_valid,
    input logic              m_ready,
    input fcc_pkg::out_res_t m_res
);

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res))
        else $error("stalled result changed");

    // Back-pressure only when the result is stalled
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("request refused without a stalled result");

    // A taken request reaches the result register if the sink is ready while it is held
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready |=> m_valid)
        else $error("request did not reach the result register");

endmodule

bind filename_classical_cipher fcc_checker u_fcc_checker (.*);
